// ===== hdl/hsvg_pkg.sv =====
// Shared types and constants for the HSV to GRB pixel converter.
`timescale 1ns / 1ps
`default_nettype none

package hsvg_pkg;

    // Field widths.
    localparam int HUE_W   = 9;
    localparam int LEVEL_W = 8;
    localparam int SECT_W  = 4;
    localparam int REM_W   = 6;

    // Hue sector arithmetic: hue / 60 by a reciprocal multiply, exact for hue < 512.
    localparam logic [10:0]        SECTOR_RECIP = 11'd1093;
    localparam int                 RECIP_SHIFT  = 16;
    localparam logic [5:0]         DEG_PER_SECT = 6'd60;
    // 255 / 60 is exactly 17 / 4.
    localparam logic [4:0]         FRAC_MUL     = 5'd17;
    localparam int                 FRAC_SHIFT   = 2;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 8'd255;

    // Hue sector codes; codes above SECT_MAGENTA take the magenta rule.
    localparam logic [SECT_W-1:0] SECT_RED     = 4'd0;
    localparam logic [SECT_W-1:0] SECT_YELLOW  = 4'd1;
    localparam logic [SECT_W-1:0] SECT_GREEN   = 4'd2;
    localparam logic [SECT_W-1:0] SECT_CYAN    = 4'd3;
    localparam logic [SECT_W-1:0] SECT_BLUE    = 4'd4;
    localparam logic [SECT_W-1:0] SECT_MAGENTA = 4'd5;

    // Contents of the first pipeline stage.
    typedef struct packed {
        logic [SECT_W-1:0]  sector;
        logic [LEVEL_W-1:0] frac;
        logic [LEVEL_W-1:0] sat;
        logic [LEVEL_W-1:0] val;
    } hsvg_front_t;

    // Contents of the second pipeline stage: sector, grey flag, value and the three scale factors.
    typedef struct packed {
        logic [SECT_W-1:0]  sector;
        logic               grey;
        logic [LEVEL_W-1:0] val;
        logic [LEVEL_W-1:0] fac_lo;
        logic [LEVEL_W-1:0] fac_fall;
        logic [LEVEL_W-1:0] fac_rise;
    } hsvg_mid_t;

endpackage

`default_nettype wire

// ===== hdl/hsvg_front.sv =====
// First pipeline stage: hue sector and fraction within the sector.
`timescale 1ns / 1ps
`default_nettype none

module hsvg_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic [hsvg_pkg::HUE_W-1:0]   hue,
    input  wire logic [hsvg_pkg::LEVEL_W-1:0] sat,
    input  wire logic [hsvg_pkg::LEVEL_W-1:0] val,
    output logic                              out_valid,
    output hsvg_pkg::hsvg_front_t             out_data
);
    import hsvg_pkg::*;

    logic [HUE_W+10:0]  recip_prod;
    logic [SECT_W-1:0]  sector;
    logic [HUE_W-1:0]   sect_base;
    logic [HUE_W-1:0]   rem_full;
    logic [REM_W-1:0]   rem;
    logic [REM_W+4:0]   frac_prod;
    logic               valid_reg;
    hsvg_front_t        data_reg;
    hsvg_front_t        data_next;

    // Sector by reciprocal multiply, then the remainder and its scaled fraction.
    always_comb begin
        recip_prod = HUE_W'(hue) * SECTOR_RECIP;
        sector     = recip_prod[RECIP_SHIFT +: SECT_W];
        sect_base  = HUE_W'(sector) * HUE_W'(DEG_PER_SECT);
        rem_full   = hue - sect_base;
        rem        = rem_full[REM_W-1:0];
        frac_prod  = rem * FRAC_MUL;
        data_next.sector = sector;
        data_next.frac   = frac_prod[FRAC_SHIFT +: LEVEL_W];
        data_next.sat    = sat;
        data_next.val    = val;
    end

    // Stage register; valid is the only control bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/hsv_to_grb_pixel.sv =====
// Top level of the HSV to GRB pixel converter, a three-stage pipeline.
// Each result item passes the stage 1, stage 2 and output registers in that order
// before it is on m_tdata.
// Throughput: one item per cycle while the output is not stalled; each of the three
// stages holds one item and a stage moves on when the stage after it is empty or moving.
// Reset: synchronous, active low; it empties every stage; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_grb_pixel (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // hue [8:0], saturation [16:9], brightness [24:17]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // grb_word [31:0]
);
    import hsvg_pkg::*;

    logic                adv1;
    logic                adv2;
    logic                adv3;
    logic                v1;
    hsvg_front_t         d1;
    logic                v2_reg;
    hsvg_mid_t           d2_reg;
    hsvg_mid_t           d2_next;
    logic                v3_reg;
    logic [31:0]         out_reg;
    logic [31:0]         out_next;
    logic [2*LEVEL_W-1:0] prod_sf;
    logic [2*LEVEL_W-1:0] prod_sr;
    logic [2*LEVEL_W-1:0] prod_lo;
    logic [2*LEVEL_W-1:0] prod_fall;
    logic [2*LEVEL_W-1:0] prod_rise;
    logic [LEVEL_W-1:0]  lvl_lo;
    logic [LEVEL_W-1:0]  lvl_fall;
    logic [LEVEL_W-1:0]  lvl_rise;
    logic [LEVEL_W-1:0]  red;
    logic [LEVEL_W-1:0]  green;
    logic [LEVEL_W-1:0]  blue;

    // Stall chain: a stage moves when the one after it is empty or moving.
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1 || adv2;
    assign s_tready = adv1;

    // Stage 1: sector and fraction.
    hsvg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv1),
        .in_valid  (s_tvalid),
        .hue       (s_tdata[8:0]),
        .sat       (s_tdata[16:9]),
        .val       (s_tdata[24:17]),
        .out_valid (v1),
        .out_data  (d1)
    );

    // Stage 2: saturation times fraction and its complement.
    always_comb begin
        prod_sf = d1.sat * d1.frac;
        prod_sr = d1.sat * (FULL_LEVEL - d1.frac);
        d2_next.sector   = d1.sector;
        d2_next.grey     = (d1.sat == '0);
        d2_next.val      = d1.val;
        d2_next.fac_lo   = FULL_LEVEL - d1.sat;
        d2_next.fac_fall = FULL_LEVEL - prod_sf[LEVEL_W +: LEVEL_W];
        d2_next.fac_rise = FULL_LEVEL - prod_sr[LEVEL_W +: LEVEL_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1;
        end
        if (adv2) begin
            d2_reg <= d2_next;
        end
    end

    // Stage 3: scale the value by each factor and route levels to channels.
    always_comb begin
        prod_lo   = d2_reg.val * d2_reg.fac_lo;
        prod_fall = d2_reg.val * d2_reg.fac_fall;
        prod_rise = d2_reg.val * d2_reg.fac_rise;
        lvl_lo    = prod_lo[LEVEL_W +: LEVEL_W];
        lvl_fall  = prod_fall[LEVEL_W +: LEVEL_W];
        lvl_rise  = prod_rise[LEVEL_W +: LEVEL_W];
        case (d2_reg.sector)
            SECT_RED: begin
                red = d2_reg.val; green = lvl_rise;   blue = lvl_lo;
            end
            SECT_YELLOW: begin
                red = lvl_fall;   green = d2_reg.val; blue = lvl_lo;
            end
            SECT_GREEN: begin
                red = lvl_lo;     green = d2_reg.val; blue = lvl_rise;
            end
            SECT_CYAN: begin
                red = lvl_lo;     green = lvl_fall;   blue = d2_reg.val;
            end
            SECT_BLUE: begin
                red = lvl_rise;   green = lvl_lo;     blue = d2_reg.val;
            end
            default: begin
                red = d2_reg.val; green = lvl_lo;     blue = lvl_fall;
            end
        endcase
        // Zero saturation is plain grey.
        if (d2_reg.grey) begin
            red   = d2_reg.val;
            green = d2_reg.val;
            blue  = d2_reg.val;
        end
        out_next = {green, red, blue, 8'h00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv3) begin
            v3_reg <= v2_reg;
        end
        if (adv3) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

// ===== hdl/hsv_to_grb_pixel_chk.sv =====
// Port checker for the HSV to GRB pixel converter and its bind.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_grb_pixel_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // Reset leaves no item in the pipeline.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item valid right after reset");

    // A stalled result item stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its data.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    // The low byte of every result item is zero.
    a_low_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:0] == 8'h00)
        else $error("result item low byte not zero");

    // With the output free, an accepted item moves through the stage 1, stage 2 and output registers onto the output.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result item missing after pipeline latency");

endmodule

bind hsv_to_grb_pixel hsv_to_grb_pixel_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/hsv_to_grb_pixel_test.sv =====
// Self-checking testbench for the HSV to GRB pixel converter.
`timescale 1ns / 1ps

module hsv_to_grb_pixel_test;

    import hsvg_pkg::*;

    // One pixel waiting to be offered on the input channel.
    typedef struct {
        logic [HUE_W-1:0]   hue;
        logic [LEVEL_W-1:0] sat;
        logic [LEVEL_W-1:0] val;
        bit                 wait_for_drain;
    } pixel_item_t;

    localparam int RANDOM_PIXELS = 1800;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;

    pixel_item_t pending_pixels[$];
    logic [31:0] expected_grb[$];

    int  total_pixels   = 0;
    int  accepted_count = 0;
    int  checked_count  = 0;
    int  grey_count     = 0;
    int  wide_hue_count = 0;
    int  error_count    = 0;
    bit  s_taken        = 1'b0;

    hsv_to_grb_pixel dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Expected output word for one pixel; sectors above magenta share its rule.
    function automatic logic [31:0] grb_from_hsv(logic [HUE_W-1:0] hue,
                                                 logic [LEVEL_W-1:0] sat,
                                                 logic [LEVEL_W-1:0] val);
        int unsigned        h;
        int unsigned        s;
        int unsigned        v;
        int unsigned        frac;
        int unsigned        lo;
        int unsigned        fall;
        int unsigned        rise;
        logic [SECT_W-1:0]  sector;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        h = hue;
        s = sat;
        v = val;
        if (s == 0) begin
            red   = val;
            green = val;
            blue  = val;
        end else begin
            sector = SECT_W'(h / 60);
            frac   = ((h % 60) * 255) / 60;
            lo     = (v * (255 - s)) >> 8;
            fall   = (v * (255 - ((s * frac) >> 8))) >> 8;
            rise   = (v * (255 - ((s * (255 - frac)) >> 8))) >> 8;
            case (sector)
                SECT_RED: begin
                    red = val;               green = LEVEL_W'(rise); blue = LEVEL_W'(lo);
                end
                SECT_YELLOW: begin
                    red = LEVEL_W'(fall);    green = val;            blue = LEVEL_W'(lo);
                end
                SECT_GREEN: begin
                    red = LEVEL_W'(lo);      green = val;            blue = LEVEL_W'(rise);
                end
                SECT_CYAN: begin
                    red = LEVEL_W'(lo);      green = LEVEL_W'(fall); blue = val;
                end
                SECT_BLUE: begin
                    red = LEVEL_W'(rise);    green = LEVEL_W'(lo);   blue = val;
                end
                default: begin
                    red = val;               green = LEVEL_W'(lo);   blue = LEVEL_W'(fall);
                end
            endcase
        end
        return {green, red, blue, 8'h00};
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic add_pixel(int hue, int sat, int val, bit wait_for_drain);
        pixel_item_t item;
        item.hue            = HUE_W'(hue);
        item.sat            = LEVEL_W'(sat);
        item.val            = LEVEL_W'(val);
        item.wait_for_drain = wait_for_drain;
        pending_pixels.push_back(item);
        total_pixels++;
        if (sat == 0) grey_count++;
        if (hue > 359) wide_hue_count++;
    endtask

    // Random level that leans on the ends of the range.
    function automatic int pick_level();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return 255;
        return $urandom_range(0, 255);
    endfunction

    // Input driver: offers pending pixels in bursts with random gaps.
    always @(negedge aclk) begin
        int          burst_left;
        int          gap_left;
        pixel_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_pixels.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_pixels[0].wait_for_drain && expected_grb.size() != 0) begin
                // Let the pipeline empty completely before this item.
                s_tvalid <= 1'b0;
            end else begin
                item = pending_pixels.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, item.val, item.sat, item.hue};
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Output receiver: switches between stall patterns, with one long hold-off.
    always @(negedge aclk) begin
        int rx_mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_mode   = 0;
            mode_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && accepted_count >= 700) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 9) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: predicts on input handshakes and checks on output handshakes.
    always @(posedge aclk) begin
        logic [31:0] want;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_grb.push_back(grb_from_hsv(s_tdata[8:0], s_tdata[16:9], s_tdata[24:17]));
            accepted_count++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grb.size() == 0) begin
                report_mismatch($sformatf("result %08h with no pixel outstanding", m_tdata));
            end else begin
                want = expected_grb.pop_front();
                checked_count++;
                if (m_tdata !== want) begin
                    report_mismatch($sformatf(
                        "pixel %0d: grb_word %08h, expected %08h (g %02h/%02h r %02h/%02h b %02h/%02h)",
                        checked_count - 1, m_tdata, want, m_tdata[31:24], want[31:24],
                        m_tdata[23:16], want[23:16], m_tdata[15:8], want[15:8]));
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int hue;
        // Sector edges on both sides, hues past 359 and the top of the field.
        add_pixel(0,   255, 255, 1'b0);
        add_pixel(59,  255, 255, 1'b0);
        add_pixel(60,  200, 255, 1'b0);
        add_pixel(119, 200, 128, 1'b0);
        add_pixel(120, 255, 255, 1'b0);
        add_pixel(179, 1,   255, 1'b0);
        add_pixel(180, 128, 200, 1'b0);
        add_pixel(239, 255, 1,   1'b0);
        add_pixel(240, 255, 255, 1'b0);
        add_pixel(299, 170, 90,  1'b0);
        add_pixel(300, 255, 255, 1'b0);
        add_pixel(359, 255, 255, 1'b0);
        add_pixel(360, 200, 200, 1'b0);
        add_pixel(420, 255, 255, 1'b0);
        add_pixel(479, 100, 250, 1'b0);
        add_pixel(511, 255, 255, 1'b0);
        // Grey pixels ignore the hue.
        add_pixel(511, 0,   255, 1'b0);
        add_pixel(137, 0,   77,  1'b0);
        add_pixel(0,   0,   0,   1'b0);
        // Black at full saturation, the smallest nonzero levels and the largest below full.
        add_pixel(200, 255, 0,   1'b0);
        add_pixel(30,  1,   1,   1'b0);
        add_pixel(330, 254, 254, 1'b0);
        // Random pixels; two of them wait for the pipeline to drain first.
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if ($urandom_range(0, 6) == 0) hue = $urandom_range(360, 511);
            else hue = $urandom_range(0, 359);
            add_pixel(hue, pick_level(), pick_level(), (i == 0) || (i == 1200));
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (accepted_count < total_pixels || expected_grb.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Checked %0d of %0d pixels through stalls and gaps: %0d grey, %0d with hue above 359.",
                 checked_count, total_pixels, grey_count, wide_hue_count);
        if (error_count == 0 && expected_grb.size() == 0) begin
            $display("hsv_to_grb_pixel test passed");
        end else begin
            $display("hsv_to_grb_pixel test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("Timeout: %0d of %0d pixels accepted, %0d results checked.",
                 accepted_count, total_pixels, checked_count);
        $display("hsv_to_grb_pixel test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hsvg_pkg.sv
hdl/hsvg_front.sv
hdl/hsv_to_grb_pixel.sv
hdl/hsv_to_grb_pixel_chk.sv
tb/hsv_to_grb_pixel_test.sv
